[src/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_cell, the top level and the port checker; no dependencies.
package pps_pkg;

    localparam int MAX_PROC_DEF = 16;
    // Width of an entry index on the cell chain; covers up to 256 entries.
    localparam int ENTRY_W      = 8;
    // Number of table positions a 4-bit entry_index can name.
    localparam int LOAD_SLOTS   = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_RUN      = 2'd0;
    localparam logic [1:0] KIND_IDLE     = 2'd1;
    localparam logic [1:0] KIND_OVERHEAD = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    typedef struct packed {
        logic        command;
        logic [3:0]  entry_index;
        logic [7:0]  proc_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
        logic [7:0]  priority_level;
    } sched_in_t;

    typedef struct packed {
        logic [1:0]  slot_kind;
        logic [7:0]  running_id;
        logic [15:0] slot_time;
    } sched_out_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               wr;
        sched_in_t          item;
        logic               step;
        logic [ENTRY_W-1:0] step_idx;
        logic [15:0]        now;
        logic [4:0]         count;
        logic               run_valid;
        logic [ENTRY_W-1:0] run_idx;
    } pps_bcast_t;

    // Selection token handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               any_open;
        logic               run_open;
        logic               found;
        logic               best_last;
        logic [7:0]         best_pri;
        logic [7:0]         best_id;
        logic [ENTRY_W-1:0] best_idx;
    } pps_token_t;

endpackage

[src/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler.
//
// Channels: req (valid/ready) carries commands; a load writes one table
// entry and gives no result, a tick gives exactly one rsp transfer
// (run, idle, overhead or all done, with the slot time). cfg (valid/ready,
// always ready) writes overhead_slots (index 0) or process_count (index 1);
// the user must write them only while the block is idle; it is not enforced.
// Sequence: a load is written into its cell as it is taken. For a tick,
// a selection token walks the row of cells, one entry per cycle, then
// fin_reg captures it and the commit writes the decision into the output
// register. One tick is in flight at a time; the next command is taken in
// the cycle after the commit.
// Stall: the output register holds a result until rsp_ready; a new command
// is still accepted meanwhile, and a following tick holds its decision
// until the output register frees.
// Reset: finished flags clear, time 0, nothing running, no pending
// overhead, both config registers 0. Table payload is unknown until loaded.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROC_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sched_in_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output sched_out_t           rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [7:0]       ovh_cfg_reg;
    logic [4:0]       count_cfg_reg;
    logic [15:0]      time_reg;
    logic [15:0]      time_next;
    logic [7:0]       ovl_reg;
    logic [7:0]       ovl_next;
    logic             run_valid_reg;
    logic             run_valid_next;
    logic [IDX_W-1:0] run_idx_reg;
    logic [IDX_W-1:0] run_idx_next;
    pps_token_t       fin_reg;
    logic             rsp_valid_reg;
    sched_out_t       rsp_reg;

    logic             req_fire;
    logic             commit;
    logic [1:0]       kind_d;
    logic [7:0]       id_d;
    logic             adv_d;
    logic             step_d;
    logic [IDX_W-1:0] pick;
    pps_bcast_t       bcast;
    pps_token_t       tok_head;
    pps_token_t       tok [MAX_PROCESSES];

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign commit    = (state_reg == S_DECIDE) && (!rsp_valid_reg || rsp_ready);
    assign pick      = fin_reg.best_idx[IDX_W-1:0];

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = req_fire && (req.command == CMD_TICK);
    end

    always_comb
    begin
        bcast           = '0;
        bcast.wr        = req_fire && (req.command == CMD_LOAD);
        bcast.item      = req;
        bcast.step      = commit && step_d;
        bcast.step_idx  = fin_reg.best_idx;
        bcast.now       = time_reg;
        bcast.count     = count_cfg_reg;
        bcast.run_valid = run_valid_reg;
        bcast.run_idx   = ENTRY_W'(run_idx_reg);
    end

    for (genvar g = 0; g < MAX_PROCESSES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            pps_cell #(
                .CELL_INDEX    (g),
                .MAX_PROCESSES (MAX_PROCESSES)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .bcast   (bcast),
                .tok_in  (tok_head),
                .tok_out (tok[g])
            );
        end
        else
        begin : g_body
            pps_cell #(
                .CELL_INDEX    (g),
                .MAX_PROCESSES (MAX_PROCESSES)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .bcast   (bcast),
                .tok_in  (tok[g-1]),
                .tok_out (tok[g])
            );
        end
    end

    // Slot decision from the captured token.
    always_comb
    begin
        kind_d         = KIND_RUN;
        id_d           = 8'd0;
        adv_d          = 1'b1;
        step_d         = 1'b0;
        ovl_next       = ovl_reg;
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (!fin_reg.any_open)
        begin
            kind_d   = KIND_DONE;
            adv_d    = 1'b0;
            ovl_next = 8'd0;
        end
        else if (ovl_reg != 8'd0)
        begin
            kind_d   = KIND_OVERHEAD;
            ovl_next = ovl_reg - 8'd1;
        end
        else if (!fin_reg.found)
        begin
            kind_d         = KIND_IDLE;
            run_valid_next = 1'b0;
        end
        else if (run_valid_reg && (run_idx_reg != pick) && fin_reg.run_open
                 && (ovh_cfg_reg != 8'd0))
        begin
            kind_d         = KIND_OVERHEAD;
            run_valid_next = 1'b0;
            ovl_next       = ovh_cfg_reg - 8'd1;
        end
        else
        begin
            // Covers a preemption with no overhead: the new pick runs now.
            kind_d         = KIND_RUN;
            id_d           = fin_reg.best_id;
            step_d         = 1'b1;
            run_valid_next = !fin_reg.best_last;
            run_idx_next   = pick;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tok_head.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_PROCESSES-1].valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign time_next = adv_d ? time_reg + 16'd1 : time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ovh_cfg_reg   <= 8'd0;
            count_cfg_reg <= 5'd0;
            time_reg      <= 16'd0;
            ovl_reg       <= 8'd0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OVERHEAD: ovh_cfg_reg   <= cfg_data;
                    CFG_COUNT:    count_cfg_reg <= cfg_data[4:0];
                    default:      ;
                endcase
            end
            if (commit)
            begin
                time_reg      <= time_next;
                ovl_reg       <= ovl_next;
                run_valid_reg <= run_valid_next;
                run_idx_reg   <= run_idx_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && tok[MAX_PROCESSES-1].valid)
        begin
            fin_reg <= tok[MAX_PROCESSES-1];
        end
        if (commit)
        begin
            rsp_reg.slot_kind  <= kind_d;
            rsp_reg.running_id <= id_d;
            rsp_reg.slot_time  <= time_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/pps_cell.sv]
// One process table entry with its slice of the selection scan.
// Depends on pps_pkg for the broadcast and token types.
module pps_cell
    import pps_pkg::*;
#(
    parameter int CELL_INDEX    = 0,
    parameter int MAX_PROCESSES = MAX_PROC_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pps_bcast_t bcast,
    input  pps_token_t tok_in,
    output pps_token_t tok_out
);

    logic [7:0]  id_reg;
    logic [15:0] arr_reg;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [7:0]  pri_reg;
    logic        fin_reg;
    logic        fin_next;
    pps_token_t  tok_reg;
    pps_token_t  tok_next;

    logic load_hit;
    logic step_hit;
    logic active;
    logic open;
    logic better;

    // Entry index wraps modulo the table depth: match every alias of this cell.
    always_comb
    begin
        load_hit = 1'b0;
        for (int k = 0; k < LOAD_SLOTS; k++)
        begin
            if (CELL_INDEX + k * MAX_PROCESSES < LOAD_SLOTS)
            begin
                if (bcast.item.entry_index == 4'(CELL_INDEX + k * MAX_PROCESSES))
                begin
                    load_hit = 1'b1;
                end
            end
        end
    end

    assign step_hit = bcast.step && (bcast.step_idx == ENTRY_W'(CELL_INDEX));
    assign active   = ENTRY_W'(bcast.count) > ENTRY_W'(CELL_INDEX);
    assign open     = active && !fin_reg;
    assign better   = open && (arr_reg <= bcast.now)
                      && (!tok_in.found || (pri_reg < tok_in.best_pri));

    always_comb
    begin
        tok_next          = tok_in;
        tok_next.any_open = tok_in.any_open || open;
        if (bcast.run_valid && (bcast.run_idx == ENTRY_W'(CELL_INDEX)) && !fin_reg)
        begin
            tok_next.run_open = 1'b1;
        end
        // Strict compare keeps ties with the lower index.
        if (better)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_last = (rem_reg <= 16'd1);
            tok_next.best_pri  = pri_reg;
            tok_next.best_id   = id_reg;
            tok_next.best_idx  = ENTRY_W'(CELL_INDEX);
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        fin_next = fin_reg;
        if (bcast.wr && load_hit)
        begin
            rem_next = bcast.item.burst_length;
            fin_next = (bcast.item.burst_length == 16'd0);
        end
        else if (step_hit)
        begin
            if (rem_reg <= 16'd1)
            begin
                rem_next = 16'd0;
                fin_next = 1'b1;
            end
            else
            begin
                rem_next = rem_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (bcast.wr && load_hit)
        begin
            id_reg  <= bcast.item.proc_id;
            arr_reg <= bcast.item.arrival_time;
            pri_reg <= bcast.item.priority_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            fin_reg <= fin_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[src/pps_checker.sv]
// Port-level checks for the preemptive priority scheduler, bound to the top.
// Depends on pps_pkg for payload types and slot kind codes.
module pps_checker
    import pps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input sched_in_t  req,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input sched_out_t rsp
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    // Only run slots carry an identifier.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.slot_kind != KIND_RUN) |-> rsp.running_id == 8'd0)
        else $error("non-run slot carries an identifier");

    // A tick transfer keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.command == CMD_TICK) |=> !req_ready)
        else $error("command accepted during a scan");

    // A load transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.command == CMD_LOAD) && !rsp_valid
        |=> !rsp_valid)
        else $error("result appeared after a load");

    // A new result only follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result without a preceding tick");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
